// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the core rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, inactive while reset is asserted
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, inactive while reset is asserted
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/fcma_pkg.sv =====
// ----------------------------------------------------------------------------
// fcma_pkg
// types and constants shared by the four-channel moving average
// ----------------------------------------------------------------------------
package fcma_pkg;

	localparam int SAMPLE_W = 16;
	localparam int CHANNELS = 4;

	// channel order
	localparam int CH_FRONT = 0;
	localparam int CH_BACK  = 1;
	localparam int CH_LEFT  = 2;
	localparam int CH_RIGHT = 3;

	// uq12.4 sample or average
	typedef logic [SAMPLE_W-1:0] sample_t;

	// per-channel update control
	typedef struct packed {
		logic load;    // accepted word, update history and sum
		logic refill;  // fill whole history with the new sample first
	} chan_ctl_t;

endpackage

// ===== rtl/core/fcma_if.sv =====
// ----------------------------------------------------------------------------
// fcma_if
// valid/ready channels carrying sample words in and average words out
// ----------------------------------------------------------------------------
interface fcma_in_if;
	import fcma_pkg::*;

	logic    valid;
	logic    ready;
	logic    mode;
	sample_t front_sample;
	sample_t back_sample;
	sample_t left_sample;
	sample_t right_sample;

	modport source (
		output valid, mode, front_sample, back_sample, left_sample, right_sample,
		input  ready
	);

	modport sink (
		input  valid, mode, front_sample, back_sample, left_sample, right_sample,
		output ready
	);
endinterface

interface fcma_out_if;
	import fcma_pkg::*;

	logic    valid;
	logic    ready;
	sample_t front_average;
	sample_t back_average;
	sample_t left_average;
	sample_t right_average;

	modport source (
		output valid, front_average, back_average, left_average, right_average,
		input  ready
	);

	modport sink (
		input  valid, front_average, back_average, left_average, right_average,
		output ready
	);
endinterface

// ===== rtl/core/four_channel_moving_average.sv =====
// ----------------------------------------------------------------------------
// four_channel_moving_average
// boxcar smoothing of front, back, left and right range samples
// ----------------------------------------------------------------------------
// Each accepted word carries one uq12.4 sample per channel and a mode bit.
// Every channel keeps its last WINDOW samples and a running sum; a word with
// mode set first fills the whole history of every channel with its sample.
// The new sample always counts in the window it is averaged in, and each
// average is the window sum divided by WINDOW, truncated. After reset the
// histories hold zeros. Throughput is one word per clock unless the sink
// stalls; a result passes the running sum update, then the reciprocal
// multiply into the output register. The per-channel running sum, one
// add and one subtract a cycle, is what lets a word enter every cycle.
// samples.ready follows averages.ready combinationally through the
// two pipeline stages.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module four_channel_moving_average #(
	parameter int WINDOW = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	fcma_in_if.sink           samples,
	fcma_out_if.source        averages
);
	import fcma_pkg::*;

	// sum width and exact reciprocal for floor(sum / WINDOW):
	// m = ceil(2^(n+l) / WINDOW) with l = clog2(WINDOW) is exact for all n-bit sums
	localparam int          LOG_W    = $clog2(WINDOW);
	localparam int          SUM_W    = SAMPLE_W + LOG_W;
	localparam int          SHIFT    = SUM_W + LOG_W;
	localparam int          RECIP_W  = SUM_W + 2;
	localparam int          PROD_W   = SUM_W + RECIP_W;
	localparam logic [63:0] RECIP_64 = ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_64[RECIP_W-1:0];

	logic             accept;
	logic             s1_advance;
	logic             valid_s1;
	logic             out_valid_q;
	chan_ctl_t        ctl;
	sample_t          ch_sample [CHANNELS];
	logic [SUM_W-1:0] chan_sum  [CHANNELS];
	logic [PROD_W-1:0] prod     [CHANNELS];
	sample_t          avg_q     [CHANNELS];

	// stage 1 is the channel sum registers themselves; they may only move
	// when stage 1 is empty or hands its word on in the same cycle
	assign s1_advance    = !out_valid_q || averages.ready;
	assign samples.ready = !valid_s1 || s1_advance;
	assign accept        = samples.valid && samples.ready;

	assign ctl.load   = accept;
	assign ctl.refill = samples.mode;

	assign ch_sample[CH_FRONT] = samples.front_sample;
	assign ch_sample[CH_BACK]  = samples.back_sample;
	assign ch_sample[CH_LEFT]  = samples.left_sample;
	assign ch_sample[CH_RIGHT] = samples.right_sample;

	// one history and running sum per channel
	for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
		fcma_chan #(
			.WINDOW (WINDOW)
		) u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.sample (ch_sample[c]),
			.sum    (chan_sum[c])
		);

		// divide by WINDOW as a multiply by the reciprocal and a shift
		assign prod[c] = PROD_W'(chan_sum[c]) * PROD_W'(RECIP);
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_advance || !valid_s1) begin
			valid_s1 <= accept;
		end
	end

	// output register, holds while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance && valid_s1) begin
			for (int c = 0; c < CHANNELS; c++) begin
				avg_q[c] <= prod[c][SHIFT +: SAMPLE_W];
			end
		end
	end

	assign averages.valid         = out_valid_q;
	assign averages.front_average = avg_q[CH_FRONT];
	assign averages.back_average  = avg_q[CH_BACK];
	assign averages.left_average  = avg_q[CH_LEFT];
	assign averages.right_average = avg_q[CH_RIGHT];

	`ASSERT_NXT(a_accept_fills_s1, clk, arst_n, accept, valid_s1)
	`ASSERT_NXT(a_s1_holds_sum, clk, arst_n, valid_s1 && !s1_advance, valid_s1 && $stable(chan_sum[CH_FRONT]))
	`ASSERT_NXT(a_s1_to_out, clk, arst_n, valid_s1 && s1_advance, out_valid_q)
	`ASSERT_IMP(a_no_overrun, clk, arst_n, accept && valid_s1, s1_advance)

endmodule

// ===== rtl/core/fcma_chan.sv =====
// ----------------------------------------------------------------------------
// fcma_chan
// one channel: sample history shift line and running window sum
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcma_chan #(
	parameter int WINDOW = 8
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  fcma_pkg::chan_ctl_t                             ctl,
	input  fcma_pkg::sample_t                               sample,
	output logic [fcma_pkg::SAMPLE_W+$clog2(WINDOW)-1:0]    sum
);
	import fcma_pkg::*;

	localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);

	sample_t          hist_q [WINDOW];
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] sum_next;

	// refill gives window * sample, otherwise add newest and drop oldest
	always_comb begin
		if (ctl.refill) begin
			sum_next = SUM_W'(sample) * SUM_W'(WINDOW);
		end else begin
			sum_next = sum_q + SUM_W'(sample) - SUM_W'(hist_q[WINDOW-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '{default: '0};
			sum_q  <= '0;
		end else if (ctl.load) begin
			sum_q <= sum_next;
			if (ctl.refill) begin
				hist_q <= '{default: sample};
			end else begin
				hist_q[0] <= sample;
				for (int k = 1; k < WINDOW; k++) begin
					hist_q[k] <= hist_q[k-1];
				end
			end
		end
	end

	assign sum = sum_q;

	`ASSERT_NXT(a_refill_sum, clk, arst_n, ctl.load && ctl.refill, sum_q == SUM_W'(hist_q[WINDOW-1]) * SUM_W'(WINDOW))
	`ASSERT_NXT(a_shift_line, clk, arst_n, ctl.load && !ctl.refill, hist_q[1] == $past(hist_q[0]))
	`ASSERT_NXT(a_sum_hold, clk, arst_n, !ctl.load, $stable(sum_q) && $stable(hist_q[0]))

endmodule

// ===== verif/four_channel_moving_average_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_channel_moving_average_tb
// self-checking bench for the four-channel boxcar smoother: a scoreboard keeps
// its own window of every channel, predicts each average word from the
// accepted sample words and checks the block's output in order, while both
// handshakes idle at random
// ----------------------------------------------------------------------------
module four_channel_moving_average_tb;
	import fcma_pkg::*;

	localparam int WINDOW       = 8;
	localparam int PERIOD       = 12;
	localparam int RESET_CYC    = 7;
	localparam int LATENCY      = 2;      // running sum stage, then output register
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_WORDS = 1350;
	localparam int IDLE_PCT     = 20;
	localparam int REPORT_MAX   = 10;
	localparam int STEADY_FIRST = 320;    // words in this span see no idling at all
	localparam int STEADY_LAST  = 620;
	localparam int DRAIN_AT     = 760;    // sender holds off here until all results are in

	// one sample or average per channel, indexed by CH_FRONT .. CH_RIGHT
	typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] quad_t;

	// window predictor and in-order store of the average words still owed
	class average_checker;
		sample_t history [CHANNELS][WINDOW];
		quad_t   expected_averages [$];
		int      words_in;
		int      refills;
		int      results_seen;
		int      errors;

		function new();
			int c, k;
			for (c = 0; c < CHANNELS; c++)
				for (k = 0; k < WINDOW; k++)
					history[c][k] = '0;
			words_in     = 0;
			refills      = 0;
			results_seen = 0;
			errors       = 0;
		endfunction

		function string chan_name(int c);
			case (c)
				CH_FRONT: return "front";
				CH_BACK:  return "back";
				CH_LEFT:  return "left";
				default:  return "right";
			endcase
		endfunction

		// shift the new samples in and return the truncated window means
		function quad_t smooth(logic refill, quad_t s);
			quad_t       avg;
			logic [31:0] sum;
			int          c, k;
			for (c = 0; c < CHANNELS; c++) begin
				if (refill)
					for (k = 0; k < WINDOW; k++)
						history[c][k] = s[c];
				for (k = WINDOW - 1; k > 0; k--)
					history[c][k] = history[c][k-1];
				history[c][0] = s[c];
				sum = '0;
				for (k = 0; k < WINDOW; k++)
					sum += 32'(history[c][k]);
				avg[c] = sample_t'(sum / WINDOW);
			end
			return avg;
		endfunction

		function void note_samples(logic refill, quad_t s);
			expected_averages.push_back(smooth(refill, s));
			words_in++;
			if (refill)
				refills++;
		endfunction

		function void check_averages(quad_t got);
			quad_t want;
			int    c;
			results_seen++;
			if (expected_averages.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("%0t: average word %h with nothing outstanding", $realtime, got);
				return;
			end
			want = expected_averages.pop_front();
			for (c = 0; c < CHANNELS; c++) begin
				if (got[c] !== want[c]) begin
					errors++;
					if (errors <= REPORT_MAX)
						$display("%0t: word %0d %s average expected %h, got %h",
							$realtime, results_seen, chan_name(c), want[c], got[c]);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	fcma_in_if  samples_if ();
	fcma_out_if averages_if ();

	average_checker sb;
	int             cycles      = 0;
	int             words_sent  = 0;
	bit             steady      = 1'b0;  // no idling on either side while set

	four_channel_moving_average #(
		.WINDOW(WINDOW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_if.sink),
		.averages(averages_if.source)
	);

	always #(PERIOD / 2) clk = ~clk;

	// watchdog, reckoned well past the slowest legal run
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d averages still owed",
				cycles, sb.expected_averages.size());
			$display("four_channel_moving_average_tb: done, errors");
			$finish;
		end
	end

	// receiver: stalls at random about 20 percent of the time, never during the steady span
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			averages_if.ready <= 1'b0;
		else
			averages_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	// both handshakes are sampled at the edge, before any driver update lands
	always @(posedge clk) begin
		quad_t got;
		quad_t sent;
		if (arst_n) begin
			if (averages_if.valid && averages_if.ready) begin
				got[CH_FRONT] = averages_if.front_average;
				got[CH_BACK]  = averages_if.back_average;
				got[CH_LEFT]  = averages_if.left_average;
				got[CH_RIGHT] = averages_if.right_average;
				sb.check_averages(got);
			end
			if (samples_if.valid && samples_if.ready) begin
				sent[CH_FRONT] = samples_if.front_sample;
				sent[CH_BACK]  = samples_if.back_sample;
				sent[CH_LEFT]  = samples_if.left_sample;
				sent[CH_RIGHT] = samples_if.right_sample;
				sb.note_samples(samples_if.mode, sent);
			end
		end
	end

	function automatic quad_t fill(sample_t v);
		quad_t q;
		int    c;
		for (c = 0; c < CHANNELS; c++)
			q[c] = v;
		return q;
	endfunction

	// small step around the previous sample, clamped to the uq12.4 range
	function automatic sample_t nudge(sample_t v);
		int n;
		n = int'(v) + $urandom_range(64) - 32;
		if (n < 0)
			n = 0;
		if (n > 65535)
			n = 65535;
		return sample_t'(n);
	endfunction

	// extremes now and then, otherwise any 16-bit pattern
	function automatic sample_t any_sample();
		case ($urandom_range(3))
			0:       return '0;
			1:       return '1;
			default: return sample_t'($urandom);
		endcase
	endfunction

	// present one word, idle in front of it at random, hold until accepted
	task automatic send_word(input logic refill, input quad_t s);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			samples_if.valid <= 1'b0;
			@(posedge clk);
		end
		samples_if.valid        <= 1'b1;
		samples_if.mode         <= refill;
		samples_if.front_sample <= s[CH_FRONT];
		samples_if.back_sample  <= s[CH_BACK];
		samples_if.left_sample  <= s[CH_LEFT];
		samples_if.right_sample <= s[CH_RIGHT];
		@(posedge clk);
		while (!samples_if.ready)
			@(posedge clk);
		words_sent++;
		steady = (words_sent >= STEADY_FIRST) && (words_sent < STEADY_LAST);
	endtask

	// drop valid and wait for every owed average, then idle for the given tail
	task automatic drain(input int tail);
		samples_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_averages.size() != 0)
			@(posedge clk);
		repeat (tail)
			@(posedge clk);
	endtask

	initial begin
		quad_t s;
		quad_t base;
		int    c, k, run_len;
		bit    paused;

		sb     = new();
		paused = 1'b0;

		// every input known from time zero
		arst_n                  <= 1'b0;
		samples_if.valid        <= 1'b0;
		samples_if.mode         <= 1'b0;
		samples_if.front_sample <= '0;
		samples_if.back_sample  <= '0;
		samples_if.left_sample  <= '0;
		samples_if.right_sample <= '0;

		repeat (RESET_CYC)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// fresh histories hold zeros, so the first averages count them in
		send_word(1'b0, fill(16'hFFFF));
		s[CH_FRONT] = 16'h0001;
		s[CH_BACK]  = 16'h0010;
		s[CH_LEFT]  = 16'h0100;
		s[CH_RIGHT] = 16'h1000;
		send_word(1'b0, s);
		// all but one window slot of the largest sample, a near-widest sum
		for (k = 0; k < WINDOW - 1; k++)
			send_word(1'b0, fill(16'hFFFF));
		// refill drops the whole window at once, both ways
		send_word(1'b1, fill(16'h0000));
		send_word(1'b0, fill(16'hFFFF));
		send_word(1'b1, fill(16'hFFFF));
		send_word(1'b0, fill(16'h0000));
		// channels kept apart, alternating bit patterns
		s[CH_FRONT] = 16'hAAAA;
		s[CH_BACK]  = 16'h5555;
		s[CH_LEFT]  = 16'hFFFF;
		s[CH_RIGHT] = 16'h0000;
		send_word(1'b1, s);
		s[CH_FRONT] = 16'h5555;
		s[CH_BACK]  = 16'hAAAA;
		s[CH_LEFT]  = 16'h0000;
		s[CH_RIGHT] = 16'hFFFF;
		send_word(1'b0, s);
		// small sums that truncate toward zero
		for (k = 0; k < 3; k++)
			send_word(1'b0, fill(16'h0007));
		send_word(1'b1, fill(16'h0001));
		send_word(1'b0, fill(16'h0000));

		// --- random part ---
		// mostly tracks: a refill word then a slowly drifting run;
		// the rest are noise words with random mode and extremes
		while (words_sent < RANDOM_WORDS) begin
			if (!paused && words_sent >= DRAIN_AT) begin
				drain(0);
				paused = 1'b1;
			end
			if ($urandom_range(99) < 15) begin
				for (c = 0; c < CHANNELS; c++)
					s[c] = any_sample();
				send_word(1'($urandom_range(1)), s);
			end else begin
				for (c = 0; c < CHANNELS; c++)
					base[c] = sample_t'($urandom);
				send_word(1'b1, base);
				run_len = $urandom_range(30, 4);
				for (k = 0; k < run_len; k++) begin
					for (c = 0; c < CHANNELS; c++)
						base[c] = nudge(base[c]);
					send_word(1'b0, base);
				end
			end
		end

		// --- wind down ---
		drain(LATENCY + 8);
		if (sb.expected_averages.size() != 0) begin
			$display("%0d averages never arrived", sb.expected_averages.size());
			sb.errors += sb.expected_averages.size();
		end

		$display("ran %0d sample words (%0d with refill) and checked %0d average words",
			sb.words_in, sb.refills, sb.results_seen);
		$display("covered extremes, refills, truncation, a stall-free stretch and a full drain");
		if (sb.errors == 0)
			$display("four_channel_moving_average_tb: done, clean");
		else
			$display("four_channel_moving_average_tb: done, errors");
		$finish;
	end

endmodule

// ===== four_channel_moving_average.f =====
+incdir+rtl/core
rtl/core/fcma_pkg.sv
rtl/core/fcma_if.sv
rtl/core/fcma_chan.sv
rtl/core/four_channel_moving_average.sv
verif/four_channel_moving_average_tb.sv
